// ===== sv/tdfa_pkg.sv =====
// Shared types and constants of the table-driven automaton runner.
// Used by tdfa_table and table_driven_dfa_runner; depends on nothing.

package tdfa_pkg;

  localparam int unsigned STATE_W   = 4;
  localparam int unsigned SYMBOL_W  = 4;
  localparam int unsigned StateSpan = 1 << STATE_W;

  localparam int unsigned STATE_COUNT_DEF  = 16;
  localparam int unsigned SYMBOL_COUNT_DEF = 16;

  typedef enum logic [1:0] {
    KIND_MARK = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_READ = 2'd2,
    KIND_EOW  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    kind_e               kind;
    logic [STATE_W-1:0]  state_id;
    logic [SYMBOL_W-1:0] symbol;
    logic [STATE_W-1:0]  next_state;
    logic                accept_mark;
  } in_word_t;

  typedef struct packed {
    logic               step_ok;
    logic               accepted;
    logic [STATE_W-1:0] present_state;
    logic               dead;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] target;
  } tbl_entry_t;

endpackage

// ===== sv/table_driven_dfa_runner.sv =====
// Top level of the programmable automaton runner: control, marks, state.
// Depends on tdfa_pkg and tdfa_table.
//
// Usage:
//   Input words enter on item_i, taken at a clock edge with start high and
//   busy low. Each word gives one result word on result_o, shown for one
//   cycle with done_o high; the receiver cannot stall it.
//   Timing: the accepting edge moves the control to ST_EXEC, and the edge
//   leaving ST_EXEC registers result_o and done_o. Busy is high in ST_EXEC,
//   so a new word waits until the last word and its table write are done.
//   Configuration: cfg_we_i with cfg_wdata_i writes the initial state; it
//   takes effect at the next end-of-word word.
//   Reset: marks, current state and dead flag clear at once; then a sweep
//   clears the transition memory, one entry a cycle, over all of its
//   STATE_COUNT*SYMBOL_COUNT entries (256 by default), with busy high.
//   Add words never replace a present transition. A symbol word without a
//   transition enters the dead state until the next end-of-word word.

module table_driven_dfa_runner #(
  parameter int unsigned STATE_COUNT  = tdfa_pkg::STATE_COUNT_DEF,
  parameter int unsigned SYMBOL_COUNT = tdfa_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tdfa_pkg::in_word_t             item_i,
  output logic                           done_o,
  output tdfa_pkg::out_word_t            result_o,
  input  logic                           cfg_we_i,
  input  logic [tdfa_pkg::STATE_W-1:0]   cfg_wdata_i
);

  localparam int unsigned TblDepth  = STATE_COUNT * SYMBOL_COUNT;
  localparam int unsigned TblAw     = $clog2(TblDepth);
  localparam int unsigned MarkDepth =
    (STATE_COUNT < tdfa_pkg::StateSpan) ? STATE_COUNT : tdfa_pkg::StateSpan;
  localparam int unsigned MarkAw    = $clog2(MarkDepth);

  tdfa_pkg::ctrl_state_e             state_q, state_d;
  tdfa_pkg::in_word_t                item_q;
  logic [TblAw-1:0]                  addr_q;
  logic                              inrange_q, inrange_d;
  logic [tdfa_pkg::STATE_W-1:0]      init_q;
  logic [tdfa_pkg::STATE_W-1:0]      cur_q, cur_d;
  logic                              dead_q, dead_d;
  logic [MarkDepth-1:0]              marks_q, marks_d;
  logic                              done_q;
  tdfa_pkg::out_word_t               result_q, result_d;

  logic                              accept;
  logic                              clearing;
  logic [tdfa_pkg::STATE_W-1:0]      src_state;
  logic [31:0]                       addr_full;
  logic [TblAw-1:0]                  rd_addr;
  tdfa_pkg::tbl_entry_t              rd_entry;
  logic                              wr_en;
  tdfa_pkg::tbl_entry_t              wr_entry;
  logic                              cur_ok;
  logic                              cur_acc;

  assign busy   = clearing || (state_q != tdfa_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign src_state = (item_i.kind == tdfa_pkg::KIND_ADD) ? item_i.state_id : cur_q;
  assign addr_full = 32'(src_state) * 32'(SYMBOL_COUNT) + 32'(item_i.symbol);
  assign rd_addr   = addr_full[TblAw-1:0];

  always_comb begin
    inrange_d = 1'b0;
    case (item_i.kind)
      tdfa_pkg::KIND_ADD: begin
        inrange_d = (32'(item_i.state_id) < STATE_COUNT) &&
                    (32'(item_i.symbol) < SYMBOL_COUNT) &&
                    (32'(item_i.next_state) < STATE_COUNT);
      end
      tdfa_pkg::KIND_READ: begin
        inrange_d = (32'(cur_q) < STATE_COUNT) && (32'(item_i.symbol) < SYMBOL_COUNT);
      end
      default: begin
        inrange_d = 1'b0;
      end
    endcase
  end

  tdfa_table #(
    .Depth (TblDepth),
    .Aw    (TblAw)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (addr_q),
    .wr_data_i  (wr_entry),
    .clearing_o (clearing)
  );

  assign cur_ok  = 32'(cur_q) < STATE_COUNT;
  assign cur_acc = cur_ok && marks_q[cur_q[MarkAw-1:0]];

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    dead_d   = dead_q;
    marks_d  = marks_q;
    wr_en    = 1'b0;
    wr_entry = '{valid: 1'b1, target: item_q.next_state};
    result_d = '0;
    case (state_q)
      tdfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tdfa_pkg::ST_EXEC;
        end
      end
      tdfa_pkg::ST_EXEC: begin
        state_d = tdfa_pkg::ST_IDLE;
        case (item_q.kind)
          tdfa_pkg::KIND_MARK: begin
            if (item_q.accept_mark && (32'(item_q.state_id) < STATE_COUNT)) begin
              marks_d[item_q.state_id[MarkAw-1:0]] = 1'b1;
            end
          end
          tdfa_pkg::KIND_ADD: begin
            wr_en = inrange_q && !rd_entry.valid;
          end
          tdfa_pkg::KIND_READ: begin
            if (!dead_q) begin
              if (inrange_q && rd_entry.valid) begin
                cur_d            = rd_entry.target;
                result_d.step_ok = 1'b1;
              end else begin
                dead_d = 1'b1;
              end
            end
          end
          default: begin
            result_d.accepted = !dead_q && cur_acc;
            cur_d             = init_q;
            dead_d            = 1'b0;
          end
        endcase
        result_d.present_state = dead_d ? '0 : cur_d;
        result_d.dead          = dead_d;
      end
      default: begin
        state_d = tdfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdfa_pkg::ST_IDLE;
      init_q  <= '0;
      cur_q   <= '0;
      dead_q  <= 1'b0;
      marks_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      dead_q  <= dead_d;
      marks_q <= marks_d;
      done_q  <= (state_q == tdfa_pkg::ST_EXEC);
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q    <= item_i;
      addr_q    <= rd_addr;
      inrange_q <= inrange_d;
    end
    if (state_q == tdfa_pkg::ST_EXEC) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef ASSERT_OFF
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted word gave no result two cycles later");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy)
    else $error("word could be taken during table clearing");

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == tdfa_pkg::ST_EXEC))
    else $error("result shown without an executed word");

  a_step_not_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.step_ok |-> !result_o.dead)
    else $error("successful step reported with dead state");
`endif

endmodule

// ===== sv/tdfa_table.sv =====
// Transition table memory with a clearing sweep after reset.
// Depends on tdfa_pkg for the entry type.

module tdfa_table #(
  parameter int unsigned Depth = tdfa_pkg::STATE_COUNT_DEF * tdfa_pkg::SYMBOL_COUNT_DEF,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [Aw-1:0]        rd_addr_i,
  output tdfa_pkg::tbl_entry_t rd_data_o,
  input  logic                 wr_en_i,
  input  logic [Aw-1:0]        wr_addr_i,
  input  tdfa_pkg::tbl_entry_t wr_data_i,
  output logic                 clearing_o
);

  tdfa_pkg::tbl_entry_t mem_q [Depth];
  tdfa_pkg::tbl_entry_t rd_data_q;
  logic                 clr_act_q;
  logic [Aw-1:0]        clr_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_ptr_q <= '0;
    end else if (clr_act_q) begin
      clr_ptr_q <= clr_ptr_q + 1'b1;
      if (clr_ptr_q == Aw'(Depth - 1)) begin
        clr_act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_act_q) begin
      mem_q[clr_ptr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_act_q;

endmodule

// ===== tb/table_driven_dfa_runner_tb.sv =====
// Self-checking testbench for table_driven_dfa_runner: directed and random words
// checked against an in-bench automaton model. Depends on tdfa_pkg and the RTL.
`timescale 1ns / 100ps

module table_driven_dfa_runner_tb;

  localparam int STATE_N  = tdfa_pkg::STATE_COUNT_DEF;
  localparam int SYMBOL_N = tdfa_pkg::SYMBOL_COUNT_DEF;
  localparam int TABLE_N  = STATE_N * SYMBOL_N;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          start       = 1'b0;
  logic                          busy;
  tdfa_pkg::in_word_t            item_i      = '0;
  logic                          done_o;
  tdfa_pkg::out_word_t           result_o;
  logic                          cfg_we_i    = 1'b0;
  logic [tdfa_pkg::STATE_W-1:0]  cfg_wdata_i = '0;

  table_driven_dfa_runner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // automaton model used for prediction
  logic                         dfa_valid [TABLE_N];
  logic [tdfa_pkg::STATE_W-1:0] dfa_target [TABLE_N];
  logic                         dfa_accepting [STATE_N];
  logic [tdfa_pkg::STATE_W-1:0] dfa_cur;
  logic                         dfa_dead;
  logic [tdfa_pkg::STATE_W-1:0] dfa_init;

  // shadow of the table as the stimulus builds it, used to steer words
  logic                         gen_valid [TABLE_N];
  logic [tdfa_pkg::STATE_W-1:0] gen_target [TABLE_N];
  logic [tdfa_pkg::STATE_W-1:0] gen_cur;
  logic                         gen_dead;
  logic [tdfa_pkg::STATE_W-1:0] gen_init;

  tdfa_pkg::in_word_t  pending_q [$];
  tdfa_pkg::out_word_t expected_q [$];

  int err_count   = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_accepted  = 0;
  int n_dead      = 0;
  int n_cfg       = 0;
  int burst_left  = 0;
  int gap_left    = 0;

  function automatic tdfa_pkg::out_word_t dfa_step(tdfa_pkg::in_word_t w);
    tdfa_pkg::out_word_t r;
    int ix;
    r = '0;
    case (w.kind)
      tdfa_pkg::KIND_MARK: begin
        if (w.accept_mark && int'(w.state_id) < STATE_N) dfa_accepting[w.state_id] = 1'b1;
      end
      tdfa_pkg::KIND_ADD: begin
        if (int'(w.state_id) < STATE_N && int'(w.symbol) < SYMBOL_N &&
            int'(w.next_state) < STATE_N) begin
          ix = int'(w.state_id) * SYMBOL_N + int'(w.symbol);
          if (!dfa_valid[ix]) begin
            dfa_valid[ix]  = 1'b1;
            dfa_target[ix] = w.next_state;
          end
        end
      end
      tdfa_pkg::KIND_READ: begin
        if (!dfa_dead) begin
          ix = int'(dfa_cur) * SYMBOL_N + int'(w.symbol);
          if (int'(dfa_cur) < STATE_N && int'(w.symbol) < SYMBOL_N && dfa_valid[ix]) begin
            dfa_cur     = dfa_target[ix];
            r.step_ok   = 1'b1;
          end else begin
            dfa_dead = 1'b1;
          end
        end
      end
      default: begin
        r.accepted = !dfa_dead && int'(dfa_cur) < STATE_N && dfa_accepting[dfa_cur];
        dfa_cur    = dfa_init;
        dfa_dead   = 1'b0;
      end
    endcase
    r.present_state = dfa_dead ? '0 : dfa_cur;
    r.dead          = dfa_dead;
    return r;
  endfunction

  function automatic tdfa_pkg::in_word_t rand_word(tdfa_pkg::kind_e k);
    tdfa_pkg::in_word_t w;
    w.kind        = k;
    w.state_id    = tdfa_pkg::STATE_W'($urandom_range(0, STATE_N - 1));
    w.symbol      = tdfa_pkg::SYMBOL_W'($urandom_range(0, SYMBOL_N - 1));
    w.next_state  = tdfa_pkg::STATE_W'($urandom_range(0, STATE_N - 1));
    w.accept_mark = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic tdfa_pkg::in_word_t make_word(tdfa_pkg::kind_e k, int sid, int sym,
                                                   int nxt, bit mark);
    tdfa_pkg::in_word_t w;
    w.kind        = k;
    w.state_id    = tdfa_pkg::STATE_W'(sid);
    w.symbol      = tdfa_pkg::SYMBOL_W'(sym);
    w.next_state  = tdfa_pkg::STATE_W'(nxt);
    w.accept_mark = mark;
    return w;
  endfunction

  function automatic logic [tdfa_pkg::SYMBOL_W-1:0] pick_symbol();
    logic [tdfa_pkg::SYMBOL_W-1:0] opts [$];
    if (!gen_dead && $urandom_range(0, 99) < 85) begin
      for (int s = 0; s < SYMBOL_N; s++) begin
        if (gen_valid[int'(gen_cur) * SYMBOL_N + s]) opts.push_back(tdfa_pkg::SYMBOL_W'(s));
      end
    end
    if (opts.size() > 0) return opts[$urandom_range(0, opts.size() - 1)];
    return tdfa_pkg::SYMBOL_W'($urandom_range(0, SYMBOL_N - 1));
  endfunction

  task automatic queue_word(tdfa_pkg::in_word_t w);
    int ix;
    case (w.kind)
      tdfa_pkg::KIND_ADD: begin
        ix = int'(w.state_id) * SYMBOL_N + int'(w.symbol);
        if (!gen_valid[ix]) begin
          gen_valid[ix]  = 1'b1;
          gen_target[ix] = w.next_state;
        end
      end
      tdfa_pkg::KIND_READ: begin
        ix = int'(gen_cur) * SYMBOL_N + int'(w.symbol);
        if (!gen_dead) begin
          if (gen_valid[ix]) gen_cur = gen_target[ix];
          else gen_dead = 1'b1;
        end
      end
      tdfa_pkg::KIND_EOW: begin
        gen_cur  = gen_init;
        gen_dead = 1'b0;
      end
      default: ;
    endcase
    pending_q.push_back(w);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_initial(logic [tdfa_pkg::STATE_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= tdfa_pkg::STATE_W'($urandom_range(0, STATE_N - 1));
    gen_init = v;
    n_cfg++;
    @(negedge clk_i);
  endtask

  task automatic random_phase(int n_items);
    int count;
    int len;
    tdfa_pkg::in_word_t w;
    count = 0;
    for (int i = 0; i < 2; i++) begin
      queue_word(rand_word(tdfa_pkg::KIND_MARK));
      count++;
    end
    for (int i = 0; i < 20; i++) begin
      queue_word(rand_word(tdfa_pkg::KIND_ADD));
      count++;
    end
    while (count < n_items) begin
      len = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          queue_word(rand_word(tdfa_pkg::kind_e'($urandom_range(0, 3))));
          count++;
        end
        w = rand_word(tdfa_pkg::KIND_READ);
        w.symbol = pick_symbol();
        queue_word(w);
        count++;
      end
      queue_word(rand_word(tdfa_pkg::KIND_EOW));
      count++;
    end
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(4, 12);
    return $urandom_range(0, 3);
  endfunction

  // driver: one word per handshake, bursts separated by gaps
  always @(posedge clk_i) begin
    logic               fire;
    logic               nxt_start;
    tdfa_pkg::in_word_t nxt_item;
    fire      = start && !busy;
    nxt_start = start;
    nxt_item  = item_i;
    if (cfg_we_i) dfa_init = cfg_wdata_i;
    if (rst_ni) begin
      if (fire) begin
        expected_q.push_back(dfa_step(item_i));
        n_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) gap_left = pick_gap();
      end
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          nxt_start = 1'b0;
        end else if (pending_q.size() > 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 30);
          nxt_item  = pending_q.pop_front();
          nxt_start = 1'b1;
        end else begin
          nxt_start = 1'b0;
        end
      end
    end
    start  <= nxt_start;
    item_i <= nxt_item;
  end

  // monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk_i) begin
    tdfa_pkg::out_word_t exp_w;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result word with no word pending: %p", result_o);
        err_count++;
      end else begin
        exp_w = expected_q.pop_front();
        n_checked++;
        if (exp_w.accepted) n_accepted++;
        if (exp_w.dead) n_dead++;
        if (result_o.step_ok !== exp_w.step_ok) begin
          $error("step_ok: expected %0d, got %0d", exp_w.step_ok, result_o.step_ok);
          err_count++;
        end
        if (result_o.accepted !== exp_w.accepted) begin
          $error("accepted: expected %0d, got %0d", exp_w.accepted, result_o.accepted);
          err_count++;
        end
        if (result_o.present_state !== exp_w.present_state) begin
          $error("present_state: expected %0d, got %0d", exp_w.present_state,
                 result_o.present_state);
          err_count++;
        end
        if (result_o.dead !== exp_w.dead) begin
          $error("dead: expected %0d, got %0d", exp_w.dead, result_o.dead);
          err_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_N; i++) begin
      dfa_valid[i]  = 1'b0;
      dfa_target[i] = '0;
      gen_valid[i]  = 1'b0;
      gen_target[i] = '0;
    end
    for (int i = 0; i < STATE_N; i++) dfa_accepting[i] = 1'b0;
    dfa_cur  = '0;
    dfa_dead = 1'b0;
    dfa_init = '0;
    gen_cur  = '0;
    gen_dead = 1'b0;
    gen_init = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_word(make_word(tdfa_pkg::KIND_MARK, 3, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_MARK, 15, 0, 0, 1'b1));
    queue_word(make_word(tdfa_pkg::KIND_MARK, 0, 0, 0, 1'b1));
    queue_word(make_word(tdfa_pkg::KIND_ADD, 0, 0, 15, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_ADD, 0, 0, 3, 1'b1));
    queue_word(make_word(tdfa_pkg::KIND_ADD, 15, 15, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_ADD, 15, 1, 3, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_EOW, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 15, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_EOW, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 1, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_EOW, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 5, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_EOW, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_READ, 0, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_MARK, 15, 0, 0, 1'b0));
    queue_word(make_word(tdfa_pkg::KIND_EOW, 15, 15, 15, 1'b1));
    queue_word(make_word(tdfa_pkg::KIND_ADD, 15, 15, 15, 1'b1));
    queue_word(make_word(tdfa_pkg::KIND_READ, 15, 15, 15, 1'b1));

    write_initial(tdfa_pkg::STATE_W'(STATE_N - 1));
    random_phase(190);
    write_initial('0);
    random_phase(190);
    write_initial(tdfa_pkg::STATE_W'($urandom_range(1, STATE_N - 2)));
    random_phase(190);
    write_initial(tdfa_pkg::STATE_W'($urandom_range(0, STATE_N - 1)));
    random_phase(190);
    write_initial(tdfa_pkg::STATE_W'(STATE_N - 1));
    random_phase(190);
    write_initial(tdfa_pkg::STATE_W'($urandom_range(0, STATE_N - 1)));
    random_phase(190);

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("summary: %0d words sent, %0d results checked, %0d initial-state writes",
             n_sent, n_checked, n_cfg);
    $display("summary: %0d words accepted at end of word, %0d results in the dead state",
             n_accepted, n_dead);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
